### rtl/core/cisf_pkg.sv
package cisf_pkg;

  localparam int unsigned DEFAULT_QUERY_CAPACITY = 256;
  localparam int unsigned COUNT_W = 32;

  localparam logic ACTION_QUERY = 1'b0;
  localparam logic ACTION_PATH  = 1'b1;

  typedef struct packed {
    logic       fire;
    logic       action;
    logic [7:0] ch;
    logic       last;
  } step_t;

  typedef struct packed {
    logic new_query;
    logic hit;
  } resp_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

### rtl/core/case_insensitive_substring_filter.sv
// case-insensitive substring filter
// one input channel (in_valid/in_ready) carries requests of action, byte_value and
// last; action 0 loads a query byte, action 1 streams a path byte. the first
// query byte after a finished query starts a new one and clears the counters;
// bytes beyond QUERY_CAPACITY - 1 are dropped. A-Z is folded to lower case.
// the result channel (out_valid/out_ready) gives one request per finished path
// (path byte with last set): match, path_number and match_total.
// a request passes an input register and a result register: out_valid rises
// once a finished path reaches the result register; one request is taken every
// cycle while the receiver does not stall. the whole query is compared against
// each byte in parallel. when the receiver stalls, the held result stays and
// the input register still takes one more request; further requests wait only
// if that request itself has a result to deliver.
// reset (rst, synchronous) empties the query, marks it complete, clears the
// counters and both register stages; no clearing pass is needed.
module case_insensitive_substring_filter #(
  parameter int unsigned QUERY_CAPACITY = cisf_pkg::DEFAULT_QUERY_CAPACITY
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         action,
  input  logic [7:0]                   byte_value,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         match,
  output logic [cisf_pkg::COUNT_W-1:0] path_number,
  output logic [cisf_pkg::COUNT_W-1:0] match_total
);

  localparam logic [cisf_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  logic                         s1_valid;
  logic                         s1_action;
  logic [7:0]                   s1_byte;
  logic                         s1_last;
  logic                         s1_result;
  logic                         s1_fire;
  logic [cisf_pkg::COUNT_W-1:0] path_counter;
  logic [cisf_pkg::COUNT_W-1:0] match_counter;
  logic [cisf_pkg::COUNT_W-1:0] path_counter_next;
  logic [cisf_pkg::COUNT_W-1:0] match_counter_next;
  cisf_pkg::step_t              step;
  cisf_pkg::resp_t              resp;

  always_comb begin
    s1_result = (s1_action == cisf_pkg::ACTION_PATH) && s1_last;
    s1_fire   = s1_valid && (!s1_result || !out_valid || out_ready);
    in_ready  = !s1_valid || s1_fire;
    step.fire   = s1_fire;
    step.action = s1_action;
    step.ch     = s1_byte;
    step.last   = s1_last;
    path_counter_next  = path_counter;
    match_counter_next = match_counter;
    if (path_counter != COUNT_MAX) begin
      path_counter_next = path_counter + 1'b1;
    end
    if (resp.hit && (match_counter != COUNT_MAX)) begin
      match_counter_next = match_counter + 1'b1;
    end
  end

  cisf_matcher #(
    .DEPTH(QUERY_CAPACITY - 1)
  ) u_matcher (
    .clk (clk),
    .rst (rst),
    .step(step),
    .resp(resp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_action <= action;
      s1_byte   <= byte_value;
      s1_last   <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      path_counter  <= '0;
      match_counter <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (resp.new_query) begin
        path_counter  <= '0;
        match_counter <= '0;
      end else if (s1_fire && s1_result) begin
        path_counter  <= path_counter_next;
        match_counter <= match_counter_next;
        out_valid     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_result) begin
      match       <= resp.hit;
      path_number <= path_counter_next;
      match_total <= match_counter_next;
    end
  end

  a_path_number_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> path_number != '0)
    else $error("result with zero path number");
  a_total_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> match_total <= path_number)
    else $error("match total above path number");
  a_match_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && match) |-> match_total != '0)
    else $error("match with zero total");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

### rtl/core/cisf_matcher.sv
module cisf_matcher #(
  parameter int unsigned DEPTH = cisf_pkg::DEFAULT_QUERY_CAPACITY - 1
) (
  input  logic            clk,
  input  logic            rst,
  input  cisf_pkg::step_t step,
  output cisf_pkg::resp_t resp
);

  logic [7:0]       store [DEPTH];
  logic [DEPTH-1:0] len_mask;
  logic [DEPTH-1:0] hits;
  logic             found;
  logic             complete;

  logic [7:0]       ch;
  logic [DEPTH-1:0] eq;
  logic [DEPTH-1:0] top_pos;
  logic [DEPTH-1:0] wr_pos;
  logic [DEPTH-1:0] hits_next;
  logic             found_now;
  logic             query_req;
  logic             new_query;

  always_comb begin
    ch        = cisf_pkg::fold_case(step.ch);
    query_req = step.fire && (step.action == cisf_pkg::ACTION_QUERY);
    new_query = query_req && complete;
    for (int i = 0; i < DEPTH; i++) begin
      eq[i] = (store[i] == ch);
    end
    // highest stored position, and the next free one
    top_pos   = len_mask & ~(len_mask >> 1);
    wr_pos    = ~len_mask & ((len_mask << 1) | DEPTH'(1));
    // shift-and step, limited to the stored part of the query
    hits_next = ((hits << 1) | DEPTH'(1)) & eq & len_mask;
    found_now = found || (|(hits_next & top_pos));
    resp.new_query = new_query;
    resp.hit       = found_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_mask <= '0;
      hits     <= '0;
      found    <= 1'b0;
      complete <= 1'b1;
    end else if (step.fire) begin
      if (step.action == cisf_pkg::ACTION_QUERY) begin
        if (complete) begin
          hits     <= '0;
          found    <= 1'b0;
          len_mask <= DEPTH'(1);
        end else begin
          len_mask <= len_mask | wr_pos;
        end
        complete <= step.last;
      end else if (step.last) begin
        hits  <= '0;
        found <= 1'b0;
      end else begin
        hits  <= hits_next;
        found <= found_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (query_req && (complete ? (i == 0) : wr_pos[i])) begin
        store[i] <= ch;
      end
    end
  end

  a_hits_in_query: assert property (@(posedge clk) disable iff (rst)
    (hits & ~len_mask) == '0)
    else $error("partial hit outside stored query");
  a_found_needs_query: assert property (@(posedge clk) disable iff (rst)
    found |-> len_mask[0])
    else $error("found set with empty query");
  a_new_query_clears: assert property (@(posedge clk) disable iff (rst)
    new_query |=> (len_mask == DEPTH'(1)) && !found)
    else $error("new query did not restart");

endmodule
